FILE: rtl/hpg_pkg.sv
// ----------------------------------------------------------------------------
// Halton point generator package
// Shared types, register and mode codes, and small helper functions.
// ----------------------------------------------------------------------------
package hpg_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_DIMS    = 3'd1,
    REG_BASES   = 3'd2,
    REG_SEED_LO = 3'd3,
    REG_SEED_HI = 3'd4,
    REG_LEAP_LO = 3'd5,
    REG_LEAP_HI = 3'd6
  } hpg_reg_e;

  // Digit scrambling modes.
  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_RR2   = 2'd1,
    MODE_REV   = 2'd2
  } hpg_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD_A,
    ST_BUILD_B,
    ST_LOAD,
    ST_DIGIT,
    ST_DIV,
    ST_PERM,
    ST_ACC,
    ST_FRAC,
    ST_EMIT
  } hpg_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_load;
    logic build_start;
    logic build_a;
    logic build_b;
    logic build_next_row;
    logic set_ready;
    logic dim_load;
    logic digit_start;
    logic div_step;
    logic perm_read;
    logic acc;
    logic frac_start;
    logic frac_step;
    logic out_load;
    logic dim_next;
  } hpg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic perm_ready;
    logic mode_rr2;
    logic build_a_done;
    logic build_b_done;
    logic build_last_row;
    logic n_zero;
    logic div_done;
    logic frac_done;
    logic out_free;
    logic last_dim;
  } hpg_status_t;

  localparam int unsigned DivBitsPerStep = 4;

  function automatic logic [8:0] default_prime(input logic [2:0] d);
    logic [8:0] p;
    case (d)
      3'd0:    p = 9'd2;
      3'd1:    p = 9'd3;
      3'd2:    p = 9'd5;
      3'd3:    p = 9'd7;
      3'd4:    p = 9'd11;
      3'd5:    p = 9'd13;
      3'd6:    p = 9'd17;
      default: p = 9'd19;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] reverse8(input logic [7:0] k);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = k[7-i];
    end
    return r;
  endfunction

endpackage

FILE: rtl/hpg_ctrl.sv
// ----------------------------------------------------------------------------
// Halton point generator controller
// Sequences table build, digit extraction, fraction division and emission.
// ----------------------------------------------------------------------------
module hpg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hpg_pkg::hpg_status_t status_i,
  output hpg_pkg::hpg_cmd_t    cmd_o
);

  hpg_pkg::hpg_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hpg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      hpg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          if (!status_i.perm_ready && status_i.mode_rr2) begin
            cmd_o.build_start = 1'b1;
            state_d = hpg_pkg::ST_BUILD_A;
          end else begin
            cmd_o.set_ready = 1'b1;
            state_d = hpg_pkg::ST_LOAD;
          end
        end
      end
      hpg_pkg::ST_BUILD_A: begin
        if (status_i.build_a_done) begin
          state_d = hpg_pkg::ST_BUILD_B;
        end else begin
          cmd_o.build_a = 1'b1;
        end
      end
      hpg_pkg::ST_BUILD_B: begin
        if (!status_i.build_b_done) begin
          cmd_o.build_b = 1'b1;
        end else if (status_i.build_last_row) begin
          cmd_o.set_ready = 1'b1;
          state_d = hpg_pkg::ST_LOAD;
        end else begin
          cmd_o.build_next_row = 1'b1;
          state_d = hpg_pkg::ST_BUILD_A;
        end
      end
      hpg_pkg::ST_LOAD: begin
        cmd_o.dim_load = 1'b1;
        state_d = hpg_pkg::ST_DIGIT;
      end
      hpg_pkg::ST_DIGIT: begin
        if (status_i.n_zero) begin
          cmd_o.frac_start = 1'b1;
          state_d = hpg_pkg::ST_FRAC;
        end else begin
          cmd_o.digit_start = 1'b1;
          state_d = hpg_pkg::ST_DIV;
        end
      end
      hpg_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = hpg_pkg::ST_PERM;
        end
      end
      hpg_pkg::ST_PERM: begin
        cmd_o.perm_read = 1'b1;
        state_d = hpg_pkg::ST_ACC;
      end
      hpg_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = hpg_pkg::ST_DIGIT;
      end
      hpg_pkg::ST_FRAC: begin
        cmd_o.frac_step = 1'b1;
        if (status_i.frac_done) begin
          state_d = hpg_pkg::ST_EMIT;
        end
      end
      hpg_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.last_dim) begin
            state_d = hpg_pkg::ST_IDLE;
          end else begin
            cmd_o.dim_next = 1'b1;
            state_d = hpg_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_d = hpg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/hpg_datapath.sv
// ----------------------------------------------------------------------------
// Halton point generator datapath
// Configuration registers, permutation memory, digit divider, fraction divider
// and the output register.
// ----------------------------------------------------------------------------
module hpg_datapath #(
  parameter int unsigned MAX_DIMS      = 8,
  parameter int unsigned MAX_BASE      = 256,
  parameter int unsigned FRACTION_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [63:0]          cfg_wdata_i,
  input  logic [31:0]          in_point_index_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [2:0]           out_dimension_o,
  output logic [31:0]          out_coordinate_fraction_o,
  output logic                 out_last_coordinate_o,
  input  hpg_pkg::hpg_cmd_t    cmd_i,
  output hpg_pkg::hpg_status_t status_o
);

  localparam int unsigned PermDepth = MAX_DIMS * 256;
  localparam int unsigned PermAw    = $clog2(PermDepth);
  localparam int unsigned NumW      = 33 + $clog2(MAX_BASE);
  localparam int unsigned FracCw    = $clog2(FRACTION_BITS);
  localparam int unsigned DivSteps  = 32 / hpg_pkg::DivBitsPerStep;
  localparam int unsigned DivCw     = $clog2(DivSteps);

  // Configuration.
  logic [1:0]  mode_q;
  logic [3:0]  dims_q;
  logic [63:0] bases_q, seed_lo_q, seed_hi_q, leap_lo_q, leap_hi_q;
  logic        perm_ready_q;

  // Control counters.
  logic [2:0]          dim_q, bd_q;
  logic [8:0]          k_q, j_q;
  logic [DivCw-1:0]    div_cnt_q;
  logic [FracCw-1:0]   frac_cnt_q;
  logic                out_full_q;

  // Payload.
  logic [31:0]              idx_q, n_q, dvd_q;
  logic [7:0]               rem_q, perm_rd_q;
  logic [NumW-1:0]          num_q, den_q;
  logic [FRACTION_BITS-1:0] frac_q;
  logic [2:0]               out_dim_q;
  logic [31:0]              out_frac_q;
  logic                     out_last_q;

  logic [7:0] perm_mem [PermDepth];

  function automatic logic [8:0] dim_base(input logic [63:0] tbl, input logic [2:0] d);
    logic [8:0] b;
    b = {1'b0, tbl[{d, 3'b000} +: 8]};
    if (b < 9'd2) b = hpg_pkg::default_prime(d);
    if (b > 9'(MAX_BASE)) b = 9'(MAX_BASE);
    return b;
  endfunction

  logic [3:0]  count;
  logic [2:0]  last_idx;
  logic [8:0]  cur_b, bd_b, last_b;
  logic [3:0]  ns;
  logic [8:0]  ns_span;
  logic [7:0]  rev_k;
  logic        rev_fits;
  logic [15:0] seed, leap;
  logic [47:0] prod;
  logic [31:0] dvd_d;
  logic [7:0]  rem_d;
  logic [7:0]  digit;
  logic [NumW:0]   frac_t;
  logic            frac_bit;
  logic            mem_we;
  logic [PermAw-1:0] mem_waddr, mem_raddr;
  logic [7:0]      mem_wdata;
  logic            cfg_hit;

  always_comb begin
    count = dims_q;
    if (count == 4'd0) count = 4'd1;
    if (count > 4'(MAX_DIMS)) count = 4'(MAX_DIMS);
    last_idx = 3'(count - 4'd1);
  end

  assign cur_b  = dim_base(bases_q, dim_q);
  assign bd_b   = dim_base(bases_q, bd_q);
  assign last_b = dim_base(bases_q, last_idx);

  // Smallest ns with 2^ns >= base of the last active dimension.
  always_comb begin
    ns = 4'd8;
    for (int i = 8; i >= 0; i--) begin
      if ((9'd1 << i) >= last_b) ns = 4'(i);
    end
    ns_span = 9'd1 << ns;
  end

  assign rev_k    = hpg_pkg::reverse8(k_q[7:0]) >> (4'd8 - ns);
  assign rev_fits = {1'b0, rev_k} < bd_b;

  assign seed = dim_q[2] ? seed_hi_q[{dim_q[1:0], 4'b0000} +: 16]
                         : seed_lo_q[{dim_q[1:0], 4'b0000} +: 16];
  assign leap = dim_q[2] ? leap_hi_q[{dim_q[1:0], 4'b0000} +: 16]
                         : leap_lo_q[{dim_q[1:0], 4'b0000} +: 16];
  assign prod = idx_q * ((leap == 16'd0) ? 16'd1 : leap);

  // Restoring division of n by the base, several quotient bits per cycle.
  always_comb begin
    logic [8:0] t;
    logic [7:0] r;
    logic [31:0] q;
    r = rem_q;
    q = dvd_q;
    for (int i = 0; i < int'(hpg_pkg::DivBitsPerStep); i++) begin
      t = {r, q[31]};
      if (t >= cur_b) begin
        t = t - cur_b;
        q = {q[30:0], 1'b1};
      end else begin
        q = {q[30:0], 1'b0};
      end
      r = t[7:0];
    end
    rem_d = r;
    dvd_d = q;
  end

  always_comb begin
    case (hpg_pkg::hpg_mode_e'(mode_q))
      hpg_pkg::MODE_RR2: digit = perm_rd_q;
      hpg_pkg::MODE_REV: digit = (rem_q == 8'd0) ? 8'd0 : 8'(cur_b - {1'b0, rem_q});
      default:           digit = rem_q;
    endcase
  end

  assign frac_t   = {num_q, 1'b0};
  assign frac_bit = frac_t >= {1'b0, den_q};

  assign mem_we    = (cmd_i.build_a && rev_fits) || cmd_i.build_b;
  assign mem_wdata = cmd_i.build_a ? rev_k : j_q[7:0];
  assign mem_waddr = PermAw'({bd_q, j_q[7:0]});
  assign mem_raddr = PermAw'({dim_q, rem_q});

  // Only writes to a known register invalidate the permutation table.
  assign cfg_hit = cfg_we_i && (cfg_index_i <= hpg_pkg::REG_LEAP_HI);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      perm_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.perm_read) begin
      perm_rd_q <= perm_mem[mem_raddr];
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= hpg_pkg::MODE_PLAIN;
      dims_q       <= 4'd1;
      bases_q      <= '0;
      seed_lo_q    <= '0;
      seed_hi_q    <= '0;
      leap_lo_q    <= 64'd281479271743489;
      leap_hi_q    <= 64'd281479271743489;
      perm_ready_q <= 1'b0;
      dim_q        <= '0;
      bd_q         <= '0;
      k_q          <= '0;
      j_q          <= '0;
      div_cnt_q    <= '0;
      frac_cnt_q   <= '0;
      out_full_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (hpg_pkg::hpg_reg_e'(cfg_index_i))
          hpg_pkg::REG_MODE:    mode_q    <= cfg_wdata_i[1:0];
          hpg_pkg::REG_DIMS:    dims_q    <= cfg_wdata_i[3:0];
          hpg_pkg::REG_BASES:   bases_q   <= cfg_wdata_i;
          hpg_pkg::REG_SEED_LO: seed_lo_q <= cfg_wdata_i;
          hpg_pkg::REG_SEED_HI: seed_hi_q <= cfg_wdata_i;
          hpg_pkg::REG_LEAP_LO: leap_lo_q <= cfg_wdata_i;
          hpg_pkg::REG_LEAP_HI: leap_hi_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        perm_ready_q <= 1'b0;
      end else if (cmd_i.set_ready) begin
        perm_ready_q <= 1'b1;
      end
      if (cmd_i.in_load) dim_q <= '0;
      if (cmd_i.dim_next) dim_q <= dim_q + 3'd1;
      if (cmd_i.build_start || cmd_i.build_next_row) begin
        k_q <= '0;
        j_q <= '0;
      end
      if (cmd_i.build_start) bd_q <= '0;
      if (cmd_i.build_next_row) bd_q <= bd_q + 3'd1;
      if (cmd_i.build_a) begin
        k_q <= k_q + 9'd1;
        if (rev_fits) j_q <= j_q + 9'd1;
      end
      if (cmd_i.build_b) j_q <= j_q + 9'd1;
      if (cmd_i.digit_start) div_cnt_q <= '0;
      if (cmd_i.div_step) div_cnt_q <= div_cnt_q + 1'b1;
      if (cmd_i.frac_start) frac_cnt_q <= '0;
      if (cmd_i.frac_step) frac_cnt_q <= frac_cnt_q + 1'b1;
      if (cmd_i.out_load) begin
        out_full_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_full_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) idx_q <= in_point_index_i;
    if (cmd_i.dim_load) begin
      n_q   <= 32'({16'd0, seed} + prod[31:0]);
      num_q <= '0;
      den_q <= NumW'(1);
    end
    if (cmd_i.digit_start) begin
      dvd_q <= n_q;
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
    if (cmd_i.acc) begin
      num_q <= NumW'(num_q * NumW'(cur_b)) + NumW'(digit);
      den_q <= NumW'(den_q * NumW'(cur_b));
      n_q   <= dvd_q;
    end
    if (cmd_i.frac_start) frac_q <= '0;
    if (cmd_i.frac_step) begin
      num_q  <= frac_bit ? NumW'(frac_t - {1'b0, den_q}) : NumW'(frac_t);
      frac_q <= {frac_q[FRACTION_BITS-2:0], frac_bit};
    end
    if (cmd_i.out_load) begin
      out_dim_q  <= dim_q;
      out_frac_q <= 32'(frac_q);
      out_last_q <= (dim_q == last_idx);
    end
  end

  always_comb begin
    status_o.perm_ready     = perm_ready_q;
    status_o.mode_rr2       = (mode_q == hpg_pkg::MODE_RR2);
    status_o.build_a_done   = (k_q >= ns_span) || (j_q >= bd_b);
    status_o.build_b_done   = (j_q >= bd_b);
    status_o.build_last_row = (bd_q == 3'(MAX_DIMS - 1));
    status_o.n_zero         = (n_q == 32'd0);
    status_o.div_done       = (div_cnt_q == DivCw'(DivSteps - 1));
    status_o.frac_done      = (frac_cnt_q == FracCw'(FRACTION_BITS - 1));
    status_o.out_free       = !out_full_q || !out_stall_i;
    status_o.last_dim       = (dim_q == last_idx);
  end

  assign out_valid_o               = out_full_q;
  assign out_dimension_o           = out_dim_q;
  assign out_coordinate_fraction_o = out_frac_q;
  assign out_last_coordinate_o     = out_last_q;

`ifndef NO_ASSERTIONS
  // An extracted digit is always below the dimension's base.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc |-> ({1'b0, rem_q} < cur_b))
    else $error("digit not below base");

  // The accumulated fraction stays proper during the final division.
  a_proper_fraction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.frac_step |-> (num_q < den_q))
    else $error("numerator reached denominator");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_full_q || !out_stall_i))
    else $error("output overwritten");

  // Table rows are only written while inside the configured depth.
  a_build_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (j_q < bd_b))
    else $error("permutation write beyond row");
`endif

endmodule

FILE: rtl/halton_point_generator_top.sv
// ----------------------------------------------------------------------------
// Halton point generator top level
// Turns each point index into one Q0.32 coordinate beat per active dimension.
// ----------------------------------------------------------------------------
// Each accepted index yields dim_count output beats, dimension 0 first, with
// last_coordinate set on the final one. The block handles one index at a time.
// Per dimension it forms seed + index * leap, then for each base-b digit of
// that value runs the divider, which retires four quotient bits per cycle,
// reads the permutation memory and accumulates; once the value is exhausted
// it runs the final long division that forms the fraction bits and hands the
// result to the output register. Base 2 with a full 32-bit value is the
// slowest case. In RR2 mode the first index after any register write first
// rebuilds the digit permutation memory, about one entry per cycle. The
// output register lets the next index be accepted while the last beat still
// waits.
module halton_point_generator_top #(
  parameter int unsigned MAX_DIMS      = 8,
  parameter int unsigned MAX_BASE      = 256,
  parameter int unsigned FRACTION_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] in_point_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_dimension_o,
  output logic [31:0] out_coordinate_fraction_o,
  output logic        out_last_coordinate_o
);

  hpg_pkg::hpg_cmd_t    cmd;
  hpg_pkg::hpg_status_t status;
  logic                 in_ready;

  // The controller sequences the work; the datapath holds all other storage.
  hpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hpg_datapath #(
    .MAX_DIMS      (MAX_DIMS),
    .MAX_BASE      (MAX_BASE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .cfg_we_i                  (cfg_we_i),
    .cfg_index_i               (cfg_index_i),
    .cfg_wdata_i               (cfg_wdata_i),
    .in_point_index_i          (in_point_index_i),
    .out_stall_i               (out_stall_i),
    .out_valid_o               (out_valid_o),
    .out_dimension_o           (out_dimension_o),
    .out_coordinate_fraction_o (out_coordinate_fraction_o),
    .out_last_coordinate_o     (out_last_coordinate_o),
    .cmd_i                     (cmd),
    .status_o                  (status)
  );

  // The input is taken only while the controller waits for a new index.
  assign in_stall_o = !in_ready;

endmodule
